### sv/ksi_pkg.sv
// ============================================================================
// ksi_pkg: shared types, constants and arithmetic steps
// Word formats, pipeline records, KS matrix tables and the single-step
// functions for square root, division, multiplication and saturation.
// ============================================================================
`default_nettype none
package ksi_pkg;

	// Number format and datapath widths.
	localparam int FRAC_BITS = 32;
	localparam int SW        = 128;             // radicand width
	localparam int RW        = 68;              // square root remainder width
	localparam int SQ_STEPS  = 64;              // one root bit per stage
	localparam int NW        = 63 + FRAC_BITS;  // dividend and quotient width
	localparam int DV_STEPS  = NW;              // one quotient bit per stage
	localparam int MW        = 130;             // magnitude width before saturation

	localparam logic [62:0] MU_RESET = 63'd1 << FRAC_BITS;
	localparam logic [63:0] MAXPOS   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MINNEG   = 64'h8000_0000_0000_0000;

	// Fault codes.
	localparam logic [1:0] FLT_OK   = 2'd0;
	localparam logic [1:0] FLT_ZERO = 2'd1;
	localparam logic [1:0] FLT_SAT  = 2'd2;

	// Rows of the doubled KS matrix: which q each column uses and its sign.
	localparam logic [1:0] BROW_Q [4][3] = '{
		'{2'd0, 2'd1, 2'd2}, '{2'd1, 2'd0, 2'd3},
		'{2'd2, 2'd3, 2'd0}, '{2'd3, 2'd2, 2'd1}};
	localparam logic BROW_NEG [4][3] = '{
		'{1'b0, 1'b0, 1'b0}, '{1'b1, 1'b0, 1'b0},
		'{1'b1, 1'b1, 1'b0}, '{1'b0, 1'b1, 1'b0}};

	typedef struct packed {
		logic signed [63:0] pos_x;
		logic signed [63:0] pos_y;
		logic signed [63:0] pos_z;
		logic signed [63:0] vel_x;
		logic signed [63:0] vel_y;
		logic signed [63:0] vel_z;
		logic signed [63:0] start_time;
	} in_word_t;

	typedef struct packed {
		logic signed [63:0] ks_q0;
		logic signed [63:0] ks_q1;
		logic signed [63:0] ks_q2;
		logic signed [63:0] ks_q3;
		logic signed [63:0] ks_p0;
		logic signed [63:0] ks_p1;
		logic signed [63:0] ks_p2;
		logic signed [63:0] ks_p3;
		logic signed [63:0] orbit_energy;
		logic signed [63:0] time_out;
		logic [1:0]         fault;
	} out_word_t;

	typedef struct packed {
		logic [SW-1:0] rad;
		logic [RW-1:0] rem;
		logic [63:0]   res;
	} sqrt_t;

	typedef struct packed {
		logic [63:0]   rem;
		logic [NW-1:0] num;
		logic [NW-1:0] quo;
	} div_t;

	typedef struct packed {
		logic [63:0] val;
		logic        sat;
	} pk_t;

	// Four 32x32 partial products: a0b0, a0b1, a1b0, a1b1.
	typedef logic [3:0][63:0] pp_t;

	// Everything one word carries down the pipeline.
	typedef struct packed {
		logic [2:0][63:0] pm;
		logic [2:0]       pn;
		logic [2:0][63:0] vm;
		logic [2:0]       vn;
		logic [63:0]      tm;
		logic             zero;
		logic [SW-1:0]    ssq;
		logic [SW-1:0]    ke;
		logic [63:0]      r;
		logic [SW-1:0]    lrad;
		logic [63:0]      lead;
		logic [3:0][63:0] q;
		logic [3:0][63:0] qm;
		logic [3:0]       qs;
		logic             sat;
		logic             en_neg;
		logic [MW-1:0]    en_mag;
	} item_t;

	// Magnitude of a two's complement word; the most negative value maps to 2^63.
	function automatic logic [63:0] mag64(logic [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	// One digit-by-digit square root step: consumes two radicand bits.
	function automatic sqrt_t sq_step(sqrt_t a);
		sqrt_t         b;
		logic [RW-1:0] rem2;
		logic [RW-1:0] trial;
		rem2  = {a.rem[RW-3:0], a.rad[SW-1:SW-2]};
		trial = {2'b00, a.res, 2'b01};
		b.rad = {a.rad[SW-3:0], 2'b00};
		if (rem2 >= trial) begin
			b.rem = rem2 - trial;
			b.res = {a.res[62:0], 1'b1};
		end else begin
			b.rem = rem2;
			b.res = {a.res[62:0], 1'b0};
		end
		return b;
	endfunction

	// One restoring division step: brings in one dividend bit.
	function automatic div_t dv_step(div_t a, logic [63:0] d);
		div_t        b;
		logic [64:0] rem2;
		rem2  = {a.rem, a.num[NW-1]};
		b.num = {a.num[NW-2:0], 1'b0};
		if (rem2 >= {1'b0, d}) begin
			b.rem = 64'(rem2 - {1'b0, d});
			b.quo = {a.quo[NW-2:0], 1'b1};
		end else begin
			b.rem = rem2[63:0];
			b.quo = {a.quo[NW-2:0], 1'b0};
		end
		return b;
	endfunction

	function automatic pp_t mul_parts(logic [63:0] a, logic [63:0] b);
		pp_t         p;
		logic [31:0] a0;
		logic [31:0] a1;
		logic [31:0] b0;
		logic [31:0] b1;
		a0   = a[31:0];
		a1   = a[63:32];
		b0   = b[31:0];
		b1   = b[63:32];
		p[0] = {32'b0, a0} * {32'b0, b0};
		p[1] = {32'b0, a0} * {32'b0, b1};
		p[2] = {32'b0, a1} * {32'b0, b0};
		p[3] = {32'b0, a1} * {32'b0, b1};
		return p;
	endfunction

	function automatic logic [127:0] mul_asm(pp_t p);
		return {p[3], p[0]} + ({64'b0, p[1]} << 32) + ({64'b0, p[2]} << 32);
	endfunction

	// Sign and magnitude to a saturated two's complement word.
	function automatic pk_t pack(logic neg, logic [MW-1:0] m);
		pk_t o;
		o.sat = 1'b0;
		if (neg) begin
			if (m > MW'(MINNEG)) begin
				o.val = MINNEG;
				o.sat = 1'b1;
			end else begin
				o.val = ~m[63:0] + 64'd1;
			end
		end else begin
			if (m > MW'(MAXPOS)) begin
				o.val = MAXPOS;
				o.sat = 1'b1;
			end else begin
				o.val = m[63:0];
			end
		end
		return o;
	endfunction

endpackage
`default_nettype wire

### sv/ksi_if.sv
// ============================================================================
// ksi_if: valid/ready channels of the KS initial state block
// One channel for Cartesian state words and one for KS result words.
// ============================================================================
`default_nettype none
interface ksi_in_if;
	logic               valid;
	logic               ready;
	ksi_pkg::in_word_t  word;
	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

interface ksi_out_if;
	logic               valid;
	logic               ready;
	ksi_pkg::out_word_t word;
	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface
`default_nettype wire

### sv/cartesian_to_ks_initial_state.sv
// ============================================================================
// cartesian_to_ks_initial_state: Cartesian state to KS regularized state
// Fully pipelined conversion of position, velocity and epoch to KS
// coordinates, momenta and specific orbital energy in Q31.32.
// ============================================================================
// The block accepts one state word per clock while the output is not stalled
// and returns one result word per word, in order.
// Most stages are in the two digit-by-digit square roots (|x| and the lead
// KS coordinate, one root bit per stage, 64 stages each) and the radix-2
// dividers that follow (one quotient bit per stage, 95 stages); the remaining
// stages hold the magnitude, 32x32 multiplier, summing and saturation steps.
// A stall on the output holds the whole pipeline. Write grav_parameter only
// while no word is in flight.
`default_nettype none
module cartesian_to_ks_initial_state (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [62:0] cfg_data,
	ksi_in_if.sink      cart,
	ksi_out_if.source   ks
);

	localparam int SQ = ksi_pkg::SQ_STEPS;
	localparam int DV = ksi_pkg::DV_STEPS;

	logic [62:0]            grav_q;
	logic                   adv;
	logic [14:1]            vld_s;
	logic [SQ:1]            sr_vld_s;
	logic [SQ:1]            sl_vld_s;
	logic [DV:1]            dv_vld_s;

	ksi_pkg::in_word_t      in_s1;
	ksi_pkg::item_t         it2_d, it5_d, it6_d, it7_d, it8_d, it9_d;
	ksi_pkg::item_t         it_s2, it_s3, it_s4, it_s5, it_s6, it_s7;
	ksi_pkg::item_t         it_s8, it_s9, it_s10, it_s11, it_s12, it_s13;
	ksi_pkg::pp_t           pp_sq_s3 [6];
	logic [127:0]           sq_s4 [6];

	ksi_pkg::sqrt_t         sr_in, sl_in;
	ksi_pkg::sqrt_t         sr_s [1:SQ];
	ksi_pkg::sqrt_t         sl_s [1:SQ];
	ksi_pkg::item_t         sri_s [1:SQ];
	ksi_pkg::item_t         sli_s [1:SQ];

	ksi_pkg::div_t          dy_in, dz_in, dm_in;
	ksi_pkg::div_t          dy_s [1:DV];
	ksi_pkg::div_t          dz_s [1:DV];
	ksi_pkg::div_t          dm_s [1:DV];
	ksi_pkg::item_t         di_s [1:DV];

	ksi_pkg::pp_t           pp_s10 [4][3];
	logic                   sg_s10 [4][3];
	logic [127:0]           prod_s11 [4][3];
	logic                   sg_s11 [4][3];
	logic [ksi_pkg::MW-1:0] pos_d [4];
	logic [ksi_pkg::MW-1:0] neg_d [4];
	logic [ksi_pkg::MW-1:0] pos_s12 [4];
	logic [ksi_pkg::MW-1:0] neg_s12 [4];
	logic [ksi_pkg::MW-1:0] mag_s13 [4];
	logic                   mneg_s13 [4];
	ksi_pkg::out_word_t     out_d;
	ksi_pkg::out_word_t     out_s14;

	// Gravitational parameter register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= ksi_pkg::MU_RESET;
		end else if (cfg_we) begin
			grav_q <= cfg_data;
		end
	end

	// The whole pipeline moves unless a finished word waits at the output.
	assign adv        = !vld_s[14] || ks.ready;
	assign cart.ready = adv;
	assign ks.valid   = vld_s[14];
	assign ks.word    = out_s14;

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s    <= '0;
			sr_vld_s <= '0;
			sl_vld_s <= '0;
			dv_vld_s <= '0;
		end else if (adv) begin
			vld_s[1]   <= cart.valid;
			vld_s[5:2] <= vld_s[4:1];
			sr_vld_s   <= {sr_vld_s[SQ-1:1], vld_s[5]};
			vld_s[6]   <= sr_vld_s[SQ];
			sl_vld_s   <= {sl_vld_s[SQ-1:1], vld_s[6]};
			vld_s[7]   <= sl_vld_s[SQ];
			dv_vld_s   <= {dv_vld_s[DV-1:1], vld_s[7]};
			vld_s[8]   <= dv_vld_s[DV];
			vld_s[14:9] <= vld_s[13:8];
		end
	end

	// Stage 1 registers the input word.
	always_ff @(posedge clk) begin
		if (adv) begin
			in_s1 <= cart.word;
		end
	end

	// Stage 2 splits components into sign and magnitude.
	always_comb begin
		it2_d       = '0;
		it2_d.pm[0] = ksi_pkg::mag64(in_s1.pos_x);
		it2_d.pm[1] = ksi_pkg::mag64(in_s1.pos_y);
		it2_d.pm[2] = ksi_pkg::mag64(in_s1.pos_z);
		it2_d.pn    = {in_s1.pos_z[63], in_s1.pos_y[63], in_s1.pos_x[63]};
		it2_d.vm[0] = ksi_pkg::mag64(in_s1.vel_x);
		it2_d.vm[1] = ksi_pkg::mag64(in_s1.vel_y);
		it2_d.vm[2] = ksi_pkg::mag64(in_s1.vel_z);
		it2_d.vn    = {in_s1.vel_z[63], in_s1.vel_y[63], in_s1.vel_x[63]};
		it2_d.tm    = in_s1.start_time;
		it2_d.zero  = (in_s1.pos_x == '0) && (in_s1.pos_y == '0) && (in_s1.pos_z == '0);
	end

	// Stages 2 to 4: squares of the magnitudes as partials, then assembled.
	always_ff @(posedge clk) begin
		if (adv) begin
			it_s2 <= it2_d;
			it_s3 <= it_s2;
			it_s4 <= it_s3;
			for (int i = 0; i < 3; i++) begin
				pp_sq_s3[i]     <= ksi_pkg::mul_parts(it_s2.pm[i], it_s2.pm[i]);
				pp_sq_s3[3 + i] <= ksi_pkg::mul_parts(it_s2.vm[i], it_s2.vm[i]);
			end
			for (int i = 0; i < 6; i++) begin
				sq_s4[i] <= ksi_pkg::mul_asm(pp_sq_s3[i]);
			end
		end
	end

	// Stage 5 sums |x|^2 and takes half of |v|^2 in fixed point.
	always_comb begin
		it5_d     = it_s4;
		it5_d.ssq = sq_s4[0] + sq_s4[1] + sq_s4[2];
		it5_d.ke  = (sq_s4[3] + sq_s4[4] + sq_s4[5]) >> (ksi_pkg::FRAC_BITS + 1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s5 <= it5_d;
		end
	end

	// Square root pipeline for r.
	assign sr_in = '{rad: it_s5.ssq, rem: '0, res: '0};

	for (genvar k = 1; k <= SQ; k++) begin : g_sr
		if (k == 1) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) begin
					sr_s[k]  <= ksi_pkg::sq_step(sr_in);
					sri_s[k] <= it_s5;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv) begin
					sr_s[k]  <= ksi_pkg::sq_step(sr_s[k - 1]);
					sri_s[k] <= sri_s[k - 1];
				end
			end
		end
	end

	// Stage 6 forms the radicand of the lead coordinate, (r + |x|) / 2.
	always_comb begin
		logic [64:0] rsum;
		it6_d      = sri_s[SQ];
		it6_d.r    = sr_s[SQ].res;
		rsum       = {1'b0, sr_s[SQ].res} + {1'b0, sri_s[SQ].pm[0]};
		it6_d.lrad = ksi_pkg::SW'(rsum) << (ksi_pkg::FRAC_BITS - 1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s6 <= it6_d;
		end
	end

	// Square root pipeline for the lead coordinate.
	assign sl_in = '{rad: it_s6.lrad, rem: '0, res: '0};

	for (genvar k = 1; k <= SQ; k++) begin : g_sl
		if (k == 1) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) begin
					sl_s[k]  <= ksi_pkg::sq_step(sl_in);
					sli_s[k] <= it_s6;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv) begin
					sl_s[k]  <= ksi_pkg::sq_step(sl_s[k - 1]);
					sli_s[k] <= sli_s[k - 1];
				end
			end
		end
	end

	// Stage 7 holds the lead coordinate.
	always_comb begin
		it7_d      = sli_s[SQ];
		it7_d.lead = sl_s[SQ].res;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s7 <= it7_d;
		end
	end

	// Divider pipelines: |y|/(2 lead), |z|/(2 lead) and mu/r.
	assign dy_in = '{rem: '0, quo: '0,
		num: ksi_pkg::NW'(it_s7.pm[1]) << (ksi_pkg::FRAC_BITS - 1)};
	assign dz_in = '{rem: '0, quo: '0,
		num: ksi_pkg::NW'(it_s7.pm[2]) << (ksi_pkg::FRAC_BITS - 1)};
	assign dm_in = '{rem: '0, quo: '0,
		num: ksi_pkg::NW'(grav_q) << ksi_pkg::FRAC_BITS};

	for (genvar k = 1; k <= DV; k++) begin : g_dv
		if (k == 1) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) begin
					dy_s[k] <= ksi_pkg::dv_step(dy_in, it_s7.lead);
					dz_s[k] <= ksi_pkg::dv_step(dz_in, it_s7.lead);
					dm_s[k] <= ksi_pkg::dv_step(dm_in, it_s7.r);
					di_s[k] <= it_s7;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv) begin
					dy_s[k] <= ksi_pkg::dv_step(dy_s[k - 1], di_s[k - 1].lead);
					dz_s[k] <= ksi_pkg::dv_step(dz_s[k - 1], di_s[k - 1].lead);
					dm_s[k] <= ksi_pkg::dv_step(dm_s[k - 1], di_s[k - 1].r);
					di_s[k] <= di_s[k - 1];
				end
			end
		end
	end

	// Stage 8 saturates the quotients, places the KS coordinates by the sign
	// of x and forms the energy difference as sign and magnitude.
	always_comb begin
		ksi_pkg::pk_t  pky;
		ksi_pkg::pk_t  pkz;
		logic [127:0]  pe;
		it8_d = di_s[DV];
		pky   = ksi_pkg::pack(di_s[DV].pn[1], ksi_pkg::MW'(dy_s[DV].quo));
		pkz   = ksi_pkg::pack(di_s[DV].pn[2], ksi_pkg::MW'(dz_s[DV].quo));
		it8_d.sat = pky.sat || pkz.sat;
		if (!di_s[DV].pn[0]) begin
			it8_d.q[0] = di_s[DV].lead;
			it8_d.q[1] = pky.val;
			it8_d.q[2] = pkz.val;
			it8_d.q[3] = '0;
		end else begin
			it8_d.q[0] = pky.val;
			it8_d.q[1] = di_s[DV].lead;
			it8_d.q[2] = '0;
			it8_d.q[3] = pkz.val;
		end
		pe = 128'(dm_s[DV].quo);
		if (di_s[DV].ke >= pe) begin
			it8_d.en_neg = 1'b0;
			it8_d.en_mag = ksi_pkg::MW'(di_s[DV].ke - pe);
		end else begin
			it8_d.en_neg = 1'b1;
			it8_d.en_mag = ksi_pkg::MW'(pe - di_s[DV].ke);
		end
	end

	// Stage 9 takes magnitudes and signs of the coordinates.
	always_comb begin
		it9_d = it_s8;
		for (int i = 0; i < 4; i++) begin
			it9_d.qm[i] = ksi_pkg::mag64(it_s8.q[i]);
			it9_d.qs[i] = it_s8.q[i][63];
		end
	end

	// Stages 8 to 11: momentum products as partials, then assembled.
	always_ff @(posedge clk) begin
		if (adv) begin
			it_s8  <= it8_d;
			it_s9  <= it9_d;
			it_s10 <= it_s9;
			it_s11 <= it_s10;
			for (int k = 0; k < 4; k++) begin
				for (int i = 0; i < 3; i++) begin
					pp_s10[k][i] <= ksi_pkg::mul_parts(
						it_s9.qm[ksi_pkg::BROW_Q[k][i]], it_s9.vm[i]);
					sg_s10[k][i] <= ksi_pkg::BROW_NEG[k][i]
						^ it_s9.qs[ksi_pkg::BROW_Q[k][i]] ^ it_s9.vn[i];
					prod_s11[k][i] <= ksi_pkg::mul_asm(pp_s10[k][i]);
					sg_s11[k][i]   <= sg_s10[k][i];
				end
			end
		end
	end

	// Stage 12 sums the positive and the negative products of each row.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			pos_d[k] = '0;
			neg_d[k] = '0;
			for (int i = 0; i < 3; i++) begin
				if (sg_s11[k][i]) begin
					neg_d[k] = neg_d[k] + ksi_pkg::MW'(prod_s11[k][i]);
				end else begin
					pos_d[k] = pos_d[k] + ksi_pkg::MW'(prod_s11[k][i]);
				end
			end
		end
	end

	// Stage 13 takes the row difference, doubled and truncated toward zero.
	always_ff @(posedge clk) begin
		if (adv) begin
			it_s12 <= it_s11;
			it_s13 <= it_s12;
			for (int k = 0; k < 4; k++) begin
				pos_s12[k] <= pos_d[k];
				neg_s12[k] <= neg_d[k];
				if (pos_s12[k] >= neg_s12[k]) begin
					mneg_s13[k] <= 1'b0;
					mag_s13[k]  <= (pos_s12[k] - neg_s12[k]) >> (ksi_pkg::FRAC_BITS - 1);
				end else begin
					mneg_s13[k] <= 1'b1;
					mag_s13[k]  <= (neg_s12[k] - pos_s12[k]) >> (ksi_pkg::FRAC_BITS - 1);
				end
			end
		end
	end

	// Stage 14 saturates momenta and energy and sets the fault code.
	always_comb begin
		ksi_pkg::pk_t pkp [4];
		ksi_pkg::pk_t pke;
		logic         sat;
		sat = it_s13.sat;
		for (int k = 0; k < 4; k++) begin
			pkp[k] = ksi_pkg::pack(mneg_s13[k], mag_s13[k]);
			sat    = sat || pkp[k].sat;
		end
		pke = ksi_pkg::pack(it_s13.en_neg, it_s13.en_mag);
		sat = sat || pke.sat;
		out_d.ks_q0        = it_s13.q[0];
		out_d.ks_q1        = it_s13.q[1];
		out_d.ks_q2        = it_s13.q[2];
		out_d.ks_q3        = it_s13.q[3];
		out_d.ks_p0        = pkp[0].val;
		out_d.ks_p1        = pkp[1].val;
		out_d.ks_p2        = pkp[2].val;
		out_d.ks_p3        = pkp[3].val;
		out_d.orbit_energy = pke.val;
		out_d.time_out     = it_s13.tm;
		out_d.fault        = sat ? ksi_pkg::FLT_SAT : ksi_pkg::FLT_OK;
		// A position at the origin has no KS image: report it and clear all but the time.
		if (it_s13.zero) begin
			out_d              = '0;
			out_d.time_out     = it_s13.tm;
			out_d.fault        = ksi_pkg::FLT_ZERO;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s14 <= out_d;
		end
	end

	// An accepted word enters the first stage.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		cart.valid && cart.ready |=> vld_s[1])
		else $error("accepted word did not enter the pipeline");

	// A nonzero position always has a nonzero radius.
	a_radius_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[6] && !it_s6.zero |-> it_s6.r != '0)
		else $error("radius is zero for a nonzero position");

	// For a nonzero position the divisor of the coordinate quotients is never zero.
	a_lead_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[7] && !it_s7.zero |-> it_s7.lead != '0)
		else $error("lead coordinate is zero for a nonzero position");

	// A zero position gives a cleared first coordinate, first momentum and energy.
	a_zero_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		ks.valid && ks.word.fault == ksi_pkg::FLT_ZERO
		|-> ks.word.ks_q0 == '0 && ks.word.ks_p0 == '0 && ks.word.orbit_energy == '0)
		else $error("zero position word carries nonzero results");

endmodule
`default_nettype wire
